// File: sv/quadrature_detent_decoder_accel_unit_defines.svh
// Assertion macros for the quadrature detent decoder block.
`ifndef QUADRATURE_DETENT_DECODER_ACCEL_UNIT_DEFINES_SVH
`define QUADRATURE_DETENT_DECODER_ACCEL_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, held off during reset.
`define QDD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define QDD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define QDD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define QDD_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/qdd_pkg.sv
// Package: constants, types and transition table of the quadrature detent decoder.
`timescale 1ns / 1ps
`default_nettype none

package qdd_pkg;

  // Full-step table states
  localparam logic [2:0] ST_START     = 3'd0;
  localparam logic [2:0] ST_CW_FINAL  = 3'd1;
  localparam logic [2:0] ST_CW_BEGIN  = 3'd2;
  localparam logic [2:0] ST_CW_NEXT   = 3'd3;
  localparam logic [2:0] ST_CCW_BEGIN = 3'd4;
  localparam logic [2:0] ST_CCW_FINAL = 3'd5;
  localparam logic [2:0] ST_CCW_NEXT  = 3'd6;

  // Detent codes, as reported in the result
  localparam logic [1:0] DET_NONE = 2'd0;
  localparam logic [1:0] DET_CW   = 2'd1;
  localparam logic [1:0] DET_CCW  = 2'd2;

  // Item kinds
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  // Register indexes
  localparam logic [2:0] REG_FAST_THR  = 3'd0;
  localparam logic [2:0] REG_MED_THR   = 3'd1;
  localparam logic [2:0] REG_FAST_MULT = 3'd2;
  localparam logic [2:0] REG_MED_MULT  = 3'd3;
  localparam logic [2:0] REG_SLOW_MULT = 3'd4;

  // Register reset values
  localparam logic [19:0] FAST_THR_RST  = 20'd4000;
  localparam logic [19:0] MED_THR_RST   = 20'd12000;
  localparam logic [3:0]  FAST_MULT_RST = 4'd8;
  localparam logic [3:0]  MED_MULT_RST  = 4'd3;
  localparam logic [3:0]  SLOW_MULT_RST = 4'd1;

  localparam logic signed [15:0] SUM_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SUM_MIN = -16'sh8000;

  typedef struct packed {
    logic [1:0] det;
    logic [2:0] state;
  } qdd_step_t;

  // One move of the full-step table; code is {clk_level, dt_level}.
  function automatic qdd_step_t qdd_next(input logic [2:0] cur, input logic [1:0] code);
    qdd_step_t r;
    r.det = DET_NONE;
    r.state = ST_START;
    case (cur)
      ST_CW_FINAL: begin
        case (code)
          2'd0:    r.state = ST_CW_NEXT;
          2'd1:    r.state = ST_START;
          2'd2:    r.state = ST_CW_FINAL;
          default: begin
            r.state = ST_START;
            r.det   = DET_CW;
          end
        endcase
      end
      ST_CW_BEGIN: begin
        case (code)
          2'd0:    r.state = ST_CW_NEXT;
          2'd1:    r.state = ST_CW_BEGIN;
          default: r.state = ST_START;
        endcase
      end
      ST_CW_NEXT: begin
        case (code)
          2'd0:    r.state = ST_CW_NEXT;
          2'd1:    r.state = ST_CW_BEGIN;
          2'd2:    r.state = ST_CW_FINAL;
          default: r.state = ST_START;
        endcase
      end
      ST_CCW_BEGIN: begin
        case (code)
          2'd0:    r.state = ST_CCW_NEXT;
          2'd2:    r.state = ST_CCW_BEGIN;
          default: r.state = ST_START;
        endcase
      end
      ST_CCW_FINAL: begin
        case (code)
          2'd0:    r.state = ST_CCW_NEXT;
          2'd1:    r.state = ST_CCW_FINAL;
          2'd2:    r.state = ST_START;
          default: begin
            r.state = ST_START;
            r.det   = DET_CCW;
          end
        endcase
      end
      ST_CCW_NEXT: begin
        case (code)
          2'd0:    r.state = ST_CCW_NEXT;
          2'd1:    r.state = ST_CCW_FINAL;
          2'd2:    r.state = ST_CCW_BEGIN;
          default: r.state = ST_START;
        endcase
      end
      default: begin
        // start state, and the unused code that behaves like it
        case (code)
          2'd1:    r.state = ST_CW_BEGIN;
          2'd2:    r.state = ST_CCW_BEGIN;
          default: r.state = ST_START;
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/quadrature_detent_decoder_accel_unit.sv
// Top level: full-step quadrature detent decoder with speed-weighted step sum.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+------------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | tuser: func; tdata: clk, dt, time_us
//  m_axis   | out | m_axis_tvalid/tready   | tdata: read_steps, detent, pending_now
//  apb      | in  | psel/penable/pwrite    | paddr[4:2] register index, pwdata
//
// The table step, interval compare and saturating add sit between the state
// registers and the result register, so one item is taken per clock unless
// m_axis stalls. The result register frees itself in the cycle it is taken,
// so a new transfer is accepted whenever the output is empty or drained.
// Reset (rst_ni low, asynchronous) returns the table to start, clears the
// last detent time and pending sum, and loads the register defaults.
// A stall on m_axis holds the result and backs up s_axis through tready.
`timescale 1ns / 1ps
`default_nettype none
`include "quadrature_detent_decoder_accel_unit_defines.svh"

module quadrature_detent_decoder_accel_unit
  import qdd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // [0] clk_level, [1] dt_level, [33:2] time_us
  input  wire logic [0:0]  s_axis_tuser,   // [0] func
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [15:0] read_steps, [17:16] detent,
                                           // [33:18] pending_now
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // configuration registers
  logic [19:0] fast_thr_q, med_thr_q;
  logic [3:0]  fast_mult_q, med_mult_q, slow_mult_q;

  // decoder state
  logic [2:0]         tbl_state_q, tbl_state_d;
  logic [31:0]        last_time_q, last_time_d;
  logic signed [15:0] pend_q, pend_d;

  // result register
  logic               out_valid_q;
  logic signed [15:0] read_steps_q, read_steps_d;
  logic [1:0]         detent_q, detent_d;

  logic        in_xfer;
  logic        cfg_wr;
  logic [2:0]  reg_idx;
  logic        in_func, in_clk, in_dt;
  logic [31:0] in_time;
  qdd_step_t   step;
  logic [31:0] delta;
  logic [3:0]  mult;
  logic signed [16:0] sum_wide;
  logic signed [15:0] sum_sat;

  assign in_func = s_axis_tuser[0];
  assign in_clk  = s_axis_tdata[0];
  assign in_dt   = s_axis_tdata[1];
  assign in_time = s_axis_tdata[33:2];

  // accept while the result slot is empty or being drained this cycle
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_FAST_THR:  prdata = {12'd0, fast_thr_q};
      REG_MED_THR:   prdata = {12'd0, med_thr_q};
      REG_FAST_MULT: prdata = {28'd0, fast_mult_q};
      REG_MED_MULT:  prdata = {28'd0, med_mult_q};
      REG_SLOW_MULT: prdata = {28'd0, slow_mult_q};
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_thr_q  <= FAST_THR_RST;
      med_thr_q   <= MED_THR_RST;
      fast_mult_q <= FAST_MULT_RST;
      med_mult_q  <= MED_MULT_RST;
      slow_mult_q <= SLOW_MULT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FAST_THR:  fast_thr_q  <= pwdata[19:0];
        REG_MED_THR:   med_thr_q   <= pwdata[19:0];
        REG_FAST_MULT: fast_mult_q <= pwdata[3:0];
        REG_MED_MULT:  med_mult_q  <= pwdata[3:0];
        REG_SLOW_MULT: slow_mult_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Table step, interval band and weighted step, all in one pass.
  assign step  = qdd_next(tbl_state_q, {in_clk, in_dt});
  assign delta = in_time - last_time_q;   // wraps modulo 2^32

  always_comb begin
    // fast band is tested first; an empty medium band falls through to slow
    if (delta < {12'd0, fast_thr_q}) begin
      mult = fast_mult_q;
    end else if (delta < {12'd0, med_thr_q}) begin
      mult = med_mult_q;
    end else begin
      mult = slow_mult_q;
    end
  end

  always_comb begin
    if (step.det == DET_CW) begin
      sum_wide = 17'(pend_q) - 17'(signed'({1'b0, mult}));
    end else begin
      sum_wide = 17'(pend_q) + 17'(signed'({1'b0, mult}));
    end
    // clamp when the 17-bit sum leaves the 16-bit range
    if (sum_wide[16] != sum_wide[15]) begin
      sum_sat = sum_wide[16] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_sat = sum_wide[15:0];
    end
  end

  always_comb begin
    tbl_state_d  = tbl_state_q;
    last_time_d  = last_time_q;
    pend_d       = pend_q;
    read_steps_d = 16'sd0;
    detent_d     = DET_NONE;
    if (in_func == FUNC_READ) begin
      // return the sum and clear it; table and timestamp hold
      read_steps_d = pend_q;
      pend_d       = 16'sd0;
    end else begin
      tbl_state_d = step.state;
      detent_d    = step.det;
      if (step.det != DET_NONE) begin
        last_time_d = in_time;
        pend_d      = sum_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_state_q <= ST_START;
      last_time_q <= 32'd0;
      pend_q      <= 16'sd0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        tbl_state_q <= tbl_state_d;
        last_time_q <= last_time_d;
        pend_q      <= pend_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload; pending_now is the live sum, which moves only on a transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      read_steps_q <= read_steps_d;
      detent_q     <= detent_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, pend_q, detent_q, read_steps_q};

  // A read item reports no detent and leaves the sum cleared.
  `QDD_ASSERT_NXT(a_read_clears, clk_i, rst_ni,
                  in_xfer && (in_func == FUNC_READ),
                  m_axis_tvalid && (detent_q == DET_NONE) && (pend_q == 16'sd0))
  // A reported detent always returns the table to its start state.
  `QDD_ASSERT_IMP(a_detent_to_start, clk_i, rst_ni,
                  m_axis_tvalid && (detent_q != DET_NONE),
                  tbl_state_q == ST_START)
  // An empty result slot never blocks input.
  `QDD_ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !out_valid_q, s_axis_tready)

endmodule

`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking stream and APB bench for the quadrature detent decoder top level.
module tb_top;
  import qdd_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int FAST_TURNS      = 20;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
  typedef enum logic [1:0] {GAP_BANDS, GAP_SHORT, GAP_FIXED} gap_mode_e;

  typedef struct packed {
    logic        func;
    logic        clk_lvl;
    logic        dt_lvl;
    logic [31:0] time_us;
  } pin_item_t;

  typedef struct packed {
    logic signed [15:0] read_steps;
    logic [1:0]         detent;
    logic signed [15:0] pending_now;
  } step_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  quadrature_detent_decoder_accel_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Register copies used by the predictor; updated after each APB write.
  logic [19:0] cfg_fast_thr  = FAST_THR_RST;
  logic [19:0] cfg_med_thr   = MED_THR_RST;
  logic [3:0]  cfg_fast_mult = FAST_MULT_RST;
  logic [3:0]  cfg_med_mult  = MED_MULT_RST;
  logic [3:0]  cfg_slow_mult = SLOW_MULT_RST;

  // Predicted decoder state.
  logic [2:0]         dec_state   = ST_START;
  logic [31:0]        dec_last_us = '0;
  logic signed [15:0] dec_sum     = '0;

  // Generator's view of the table, used to place timestamps on detent samples.
  logic [2:0]  gen_state   = ST_START;
  logic [31:0] gen_last_us = '0;

  pin_item_t    pin_samples_todo[$];
  step_result_t awaited_results[$];
  pin_item_t    cur_item;
  logic         in_fire = 1'b0;
  idle_mode_e   idle_mode = IDLE_NONE;
  int           issued_count = 0;
  int           accepted_count = 0;
  int           result_count = 0;
  int           mismatch_count = 0;
  int           hold_off_len = 0;
  int           held_cycles = 0;
  int           cycle_count = 0;

  // Full-step table: returns {detent, next state}; the row holds code 3 in its top slot.
  function automatic logic [4:0] table_move(input logic [2:0] st, input logic [1:0] code);
    logic [19:0] row;
    case (st)
      ST_CW_FINAL:  row = {DET_CW, ST_START, DET_NONE, ST_CW_FINAL,
                           DET_NONE, ST_START, DET_NONE, ST_CW_NEXT};
      ST_CW_BEGIN:  row = {DET_NONE, ST_START, DET_NONE, ST_START,
                           DET_NONE, ST_CW_BEGIN, DET_NONE, ST_CW_NEXT};
      ST_CW_NEXT:   row = {DET_NONE, ST_START, DET_NONE, ST_CW_FINAL,
                           DET_NONE, ST_CW_BEGIN, DET_NONE, ST_CW_NEXT};
      ST_CCW_BEGIN: row = {DET_NONE, ST_START, DET_NONE, ST_CCW_BEGIN,
                           DET_NONE, ST_START, DET_NONE, ST_CCW_NEXT};
      ST_CCW_FINAL: row = {DET_CCW, ST_START, DET_NONE, ST_START,
                           DET_NONE, ST_CCW_FINAL, DET_NONE, ST_CCW_NEXT};
      ST_CCW_NEXT:  row = {DET_NONE, ST_START, DET_NONE, ST_CCW_BEGIN,
                           DET_NONE, ST_CCW_FINAL, DET_NONE, ST_CCW_NEXT};
      // start, and the unused code that behaves like it
      default:      row = {DET_NONE, ST_START, DET_NONE, ST_CCW_BEGIN,
                           DET_NONE, ST_CW_BEGIN, DET_NONE, ST_START};
    endcase
    return row[5*code +: 5];
  endfunction

  // Apply one accepted item to the predicted state and queue the result it yields.
  task automatic advance_decoder(input pin_item_t it);
    step_result_t r;
    logic [4:0]   mv;
    logic [31:0]  gap;
    logic [3:0]   mult;
    int           sum_now;
    int           weight;
    r = '0;
    if (it.func == FUNC_READ) begin
      r.read_steps = dec_sum;
      dec_sum = '0;
    end else begin
      mv = table_move(dec_state, {it.clk_lvl, it.dt_lvl});
      dec_state = mv[2:0];
      r.detent = mv[4:3];
      if (mv[4:3] != DET_NONE) begin
        gap = it.time_us - dec_last_us;
        dec_last_us = it.time_us;
        if (gap < {12'd0, cfg_fast_thr}) mult = cfg_fast_mult;
        else if (gap < {12'd0, cfg_med_thr}) mult = cfg_med_mult;
        else mult = cfg_slow_mult;
        sum_now = dec_sum;
        weight = mult;
        sum_now = (mv[4:3] == DET_CW) ? sum_now - weight : sum_now + weight;
        if (sum_now > SUM_MAX) sum_now = SUM_MAX;
        if (sum_now < SUM_MIN) sum_now = SUM_MIN;
        dec_sum = sum_now[15:0];
      end
    end
    r.pending_now = dec_sum;
    awaited_results.push_back(r);
  endtask

  task automatic note_mismatch(input string field, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s at result %0d: expected %0d, got %0d",
               field, result_count, want, got);
  endtask

  // Interval between detents: the band edges, inside each band, and wrapping values.
  function automatic logic [31:0] pick_gap();
    logic [31:0] fast_us;
    logic [31:0] med_us;
    fast_us = {12'd0, cfg_fast_thr};
    med_us = {12'd0, cfg_med_thr};
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return fast_us - 32'd1;
      2:       return fast_us;
      3:       return med_us - 32'd1;
      4:       return med_us;
      5, 6:    return $urandom_range(0, fast_us);
      7:       return $urandom_range(fast_us, med_us);
      8:       return med_us + $urandom_range(0, 20000);
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_sample(input logic [1:0] code, input gap_mode_e mode,
                              input logic [31:0] at_time);
    pin_item_t  it;
    logic [4:0] mv;
    mv = table_move(gen_state, code);
    gen_state = mv[2:0];
    it.func = FUNC_SAMPLE;
    it.clk_lvl = code[1];
    it.dt_lvl = code[0];
    it.time_us = (mode == GAP_FIXED) ? at_time : $urandom;
    if (mv[4:3] != DET_NONE) begin
      if (mode == GAP_SHORT) it.time_us = gen_last_us + $urandom_range(0, 1000);
      else if (mode == GAP_BANDS) it.time_us = gen_last_us + pick_gap();
      gen_last_us = it.time_us;
    end
    pin_samples_todo.push_back(it);
    issued_count++;
  endtask

  task automatic queue_read();
    pin_item_t it;
    it.func = FUNC_READ;
    it.clk_lvl = 1'($urandom_range(0, 1));
    it.dt_lvl = 1'($urandom_range(0, 1));
    it.time_us = $urandom;
    pin_samples_todo.push_back(it);
    issued_count++;
  endtask

  function automatic logic [7:0] turn_path(input logic ccw);
    return ccw ? {2'd3, 2'd1, 2'd0, 2'd2} : {2'd3, 2'd2, 2'd0, 2'd1};
  endfunction

  // One full detent from rest; in band mode add contact chatter and short back-steps.
  task automatic queue_detent(input logic ccw, input gap_mode_e mode, input logic [31:0] at_time);
    logic [7:0] path;
    logic [1:0] code;
    path = turn_path(ccw);
    if (gen_state != ST_START) queue_sample(2'd3, mode, at_time);
    for (int i = 0; i < 4; i++) begin
      code = path[2*i +: 2];
      queue_sample(code, mode, at_time);
      if (mode == GAP_BANDS && i < 3 && $urandom_range(0, 99) < 30) begin
        if (i == 0 || $urandom_range(0, 1) == 0) begin
          queue_sample(code, mode, at_time);
        end else begin
          queue_sample(path[2*(i-1) +: 2], mode, at_time);
          queue_sample(code, mode, at_time);
        end
      end
    end
  endtask

  task automatic queue_random_mix(input int n_items);
    int         stop_at;
    int         pick;
    int         len;
    logic [7:0] path;
    stop_at = issued_count + n_items;
    while (issued_count < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        queue_detent(1'($urandom_range(0, 1)), GAP_BANDS, '0);
      end else if (pick < 75) begin
        queue_read();
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 4)) queue_sample(2'($urandom_range(0, 3)), GAP_BANDS, '0);
      end else begin
        // start a turn, then break it off with an arbitrary code
        if (gen_state != ST_START) queue_sample(2'd3, GAP_BANDS, '0);
        path = turn_path(1'($urandom_range(0, 1)));
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) queue_sample(path[2*i +: 2], GAP_BANDS, '0);
        queue_sample(2'($urandom_range(0, 3)), GAP_BANDS, '0);
      end
    end
  endtask

  // APB write: setup cycle, then access cycle; register updates on the access edge.
  task automatic write_reg(input logic [2:0] idx, input logic [19:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {12'd0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FAST_THR:  cfg_fast_thr = value;
      REG_MED_THR:   cfg_med_thr = value;
      REG_FAST_MULT: cfg_fast_mult = value[3:0];
      REG_MED_MULT:  cfg_med_mult = value[3:0];
      REG_SLOW_MULT: cfg_slow_mult = value[3:0];
      default: ;
    endcase
  endtask

  // Hold until every queued item is taken and every result has come back.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (accepted_count != issued_count || awaited_results.size() != 0);
  endtask

  // Drive pin samples: present the next item once the current one is taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (pin_samples_todo.size() != 0 &&
          !(idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 69) &&
          !(idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 14)) begin
        cur_item = pin_samples_todo.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, cur_item.time_us, cur_item.dt_lvl, cur_item.clk_lvl};
        s_axis_tuser <= cur_item.func;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result side backpressure; the long hold-off is counted here.
  always @(negedge clk_i) begin
    if (hold_off_len != 0 && held_cycles < hold_off_len) begin
      m_axis_tready <= 1'b0;
      held_cycles <= held_cycles + 1;
    end else if (idle_mode == IDLE_RECEIVER) begin
      m_axis_tready <= ($urandom_range(0, 99) >= 69);
    end else if (idle_mode == IDLE_BOTH) begin
      m_axis_tready <= ($urandom_range(0, 99) >= 14);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Predict on each accepted transfer, then check each result transfer in order.
  always @(posedge clk_i) begin : score
    step_result_t got;
    step_result_t want;
    in_fire = s_axis_tvalid && s_axis_tready;
    if (in_fire) begin
      advance_decoder(cur_item);
      accepted_count++;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got.read_steps = m_axis_tdata[15:0];
      got.detent = m_axis_tdata[17:16];
      got.pending_now = m_axis_tdata[33:18];
      if (awaited_results.size() == 0) begin
        note_mismatch("unrequested result", 0, got.pending_now);
      end else begin
        want = awaited_results.pop_front();
        if (got.read_steps !== want.read_steps)
          note_mismatch("read_steps", want.read_steps, got.read_steps);
        if (got.detent !== want.detent)
          note_mismatch("detent", want.detent, got.detent);
        if (got.pending_now !== want.pending_now)
          note_mismatch("pending_now", want.pending_now, got.pending_now);
      end
      result_count++;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed turns at reset settings (fast below 4000 us, medium below 12000 us).
    queue_read();
    queue_sample(2'd3, GAP_FIXED, 32'd0);
    queue_sample(2'd0, GAP_FIXED, 32'd0);
    queue_detent(1'b0, GAP_FIXED, 32'd3999);        // just inside the fast band
    queue_detent(1'b1, GAP_FIXED, 32'd7999);        // on the fast threshold: medium
    queue_detent(1'b1, GAP_FIXED, 32'd19999);       // on the medium threshold: slow
    queue_detent(1'b0, GAP_FIXED, 32'hFFFF_FFFF);   // long gap, top timestamp
    queue_detent(1'b1, GAP_FIXED, 32'h0000_001F);   // timestamp wraps: short gap
    queue_read();

    // Stall the result side early so the block backs up its input.
    hold_off_len = HOLD_OFF_CYCLES;
    queue_random_mix(300);
    wait_drained();

    // Fast band empty, medium band takes nearly everything with a zero weight.
    idle_mode = IDLE_SENDER;
    write_reg(REG_FAST_THR, 20'd0);
    write_reg(REG_MED_THR, 20'hFFFFF);
    write_reg(REG_FAST_MULT, 20'd15);
    write_reg(REG_MED_MULT, 20'd0);
    write_reg(REG_SLOW_MULT, 20'd15);
    queue_random_mix(300);
    wait_drained();

    // Medium threshold below fast: medium band empty; slow weight zero.
    idle_mode = IDLE_RECEIVER;
    write_reg(REG_FAST_THR, 20'hFFFFF);
    write_reg(REG_MED_THR, 20'd5);
    write_reg(REG_FAST_MULT, 20'd1);
    write_reg(REG_MED_MULT, 20'd7);
    write_reg(REG_SLOW_MULT, 20'd0);
    queue_random_mix(300);
    wait_drained();

    idle_mode = IDLE_BOTH;
    write_reg(REG_FAST_THR, 20'($urandom_range(1, 3000)));
    write_reg(REG_MED_THR, cfg_fast_thr + 20'($urandom_range(1, 20000)));
    write_reg(REG_FAST_MULT, 20'($urandom_range(1, 15)));
    write_reg(REG_MED_MULT, 20'($urandom_range(1, 15)));
    write_reg(REG_SLOW_MULT, 20'($urandom_range(1, 15)));
    queue_random_mix(300);
    wait_drained();

    // Heavy fast turns each way, back to back, with reads only between the groups.
    idle_mode = IDLE_NONE;
    write_reg(REG_FAST_THR, 20'hFFFFF);
    write_reg(REG_FAST_MULT, 20'd15);
    queue_read();
    repeat (FAST_TURNS) queue_detent(1'b1, GAP_SHORT, '0);
    queue_read();
    repeat (FAST_TURNS) queue_detent(1'b0, GAP_SHORT, '0);
    repeat (2) queue_detent(1'b1, GAP_SHORT, '0);
    queue_read();
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
